>>> design/ustc_pkg.sv
// shared types, constants and the month table of the unix time to calendar unit
`timescale 1ns / 1ps
`default_nettype none

package ustc_pkg;

    localparam int unsigned SECS_W  = 32;
    localparam int unsigned YEAR_W  = 12;
    localparam int unsigned MONTH_W = 4;
    localparam int unsigned DAY_W   = 5;
    localparam int unsigned HOUR_W  = 5;
    localparam int unsigned MIN_W   = 6;
    localparam int unsigned SEC_W   = 6;
    localparam int unsigned DAYS_W  = 16;
    localparam int unsigned YLEN_W  = 9;
    localparam int unsigned PROD_W  = 64;

    localparam logic [SECS_W-1:0] EPOCH_OFFSET = 32'd946684800;
    localparam logic [YEAR_W-1:0] BASE_YEAR    = 12'd2000;

    // reciprocal constants: x/60 = (x*M60)>>37, x/24 = (x*M24)>>36, exact for 32-bit x
    localparam logic [SECS_W-1:0] MAGIC_60 = 32'h8888_8889;
    localparam logic [SECS_W-1:0] MAGIC_24 = 32'hAAAA_AAAB;

    localparam logic [YLEN_W-1:0] YEAR_DAYS      = 9'd365;
    localparam logic [YLEN_W-1:0] LEAP_YEAR_DAYS = 9'd366;

    localparam logic [6:0] CENTURY_LAST = 7'd99;
    localparam logic [8:0] QUAD_LAST    = 9'd399;

    localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
    localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
    localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

    typedef enum logic [1:0] {
        STEP_SEC  = 2'd0,
        STEP_MIN  = 2'd1,
        STEP_HOUR = 2'd2
    } t_step;

    // item handed from the front to the back
    typedef struct packed {
        logic [DAYS_W-1:0] days;
        logic [HOUR_W-1:0] hour;
        logic [MIN_W-1:0]  minute;
        logic [SEC_W-1:0]  second;
    } t_item;

    // cumulative days before each month, index 0 is january
    function automatic logic [YLEN_W-1:0] month_start(input logic [MONTH_W-1:0] idx);
        logic [YLEN_W-1:0] v;
        case (idx)
            4'd0:    v = 9'd0;
            4'd1:    v = 9'd31;
            4'd2:    v = 9'd59;
            4'd3:    v = 9'd90;
            4'd4:    v = 9'd120;
            4'd5:    v = 9'd151;
            4'd6:    v = 9'd181;
            4'd7:    v = 9'd212;
            4'd8:    v = 9'd243;
            4'd9:    v = 9'd273;
            4'd10:   v = 9'd304;
            4'd11:   v = 9'd334;
            default: v = 9'd0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

>>> design/ustc_if.sv
// beat channels of the unix time to calendar unit
`timescale 1ns / 1ps
`default_nettype none

interface ustc_in_if;
    logic                          valid;
    logic                          ready;
    logic [ustc_pkg::SECS_W-1:0]   unix_seconds;

    modport source (output valid, output unix_seconds, input ready);
    modport sink   (input valid, input unix_seconds, output ready);
endinterface

interface ustc_out_if;
    logic                          valid;
    logic                          ready;
    logic [ustc_pkg::YEAR_W-1:0]   year;
    logic [ustc_pkg::MONTH_W-1:0]  month;
    logic [ustc_pkg::DAY_W-1:0]    day;
    logic [ustc_pkg::HOUR_W-1:0]   hour;
    logic [ustc_pkg::MIN_W-1:0]    minute;
    logic [ustc_pkg::SEC_W-1:0]    second;

    modport source (output valid, output year, output month, output day,
                    output hour, output minute, output second, input ready);
    modport sink   (input valid, input year, input month, input day,
                    input hour, input minute, input second, output ready);
endinterface

`default_nettype wire

>>> design/unix_seconds_to_calendar_unit.sv
// top level: unix seconds to utc gregorian calendar date and time
// the front and the queue pass each beat on to the back, which walks whole years and then
// months before it presents the result beat
// the back works on one beat per year and month walk and pops the next from the queue when idle;
// the front and the queue take following beats meanwhile
// reset: synchronous active low, clears the sequencers and the queue; no beat is held
`timescale 1ns / 1ps
`default_nettype none

module unix_seconds_to_calendar_unit #(
    parameter int unsigned QUEUE_DEPTH = 2
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    ustc_in_if.sink     i_in,
    ustc_out_if.source  o_out
);

    // front to queue
    ustc_pkg::t_item    front_item;
    logic               front_valid;
    logic               queue_ready;

    // queue to back
    ustc_pkg::t_item    queue_item;
    logic               queue_valid;
    logic               back_pop;

    // front: subtract the 2000 epoch, then three reciprocal divisions (60, 60, 24)
    ustc_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (i_in),
        .o_item       (front_item),
        .o_item_valid (front_valid),
        .i_item_ready (queue_ready)
    );

    // decouples the short front from the long calendar walk
    ustc_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_data  (front_item),
        .i_push  (front_valid),
        .o_ready (queue_ready),
        .o_data  (queue_item),
        .o_valid (queue_valid),
        .i_pop   (back_pop)
    );

    // back: walks whole years with the gregorian leap rule, then months
    ustc_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item       (queue_item),
        .i_item_valid (queue_valid),
        .o_item_pop   (back_pop),
        .o_out        (o_out)
    );

    // the front holds its item steady while the queue is full
    a_front_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (front_valid && !queue_ready) |=> front_valid && $stable(front_item))
        else $error("front item changed while waiting");

    // a result beat always carries a legal month and day
    a_month_day: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> (o_out.month >= ustc_pkg::MONTH_JAN) &&
                        (o_out.month <= ustc_pkg::MONTH_DEC) && (o_out.day != '0))
        else $error("month or day out of range");

    // time of day fields stay in range
    a_time_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> (o_out.hour < 5'd24) && (o_out.minute < 6'd60) &&
                        (o_out.second < 6'd60))
        else $error("time of day out of range");

    // nothing is presented right after reset
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out.valid && !queue_valid)
        else $error("beat present after reset");

endmodule

`default_nettype wire

>>> design/ustc_front.sv
// front: epoch shift and time-of-day split by reciprocal multiplication
`timescale 1ns / 1ps
`default_nettype none

module ustc_front (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    ustc_in_if.sink             i_in,
    output ustc_pkg::t_item     o_item,
    output logic                o_item_valid,
    input  wire logic           i_item_ready
);

    typedef enum logic [3:0] {
        F_IDLE = 4'b0001,
        F_MUL  = 4'b0010,
        F_REM  = 4'b0100,
        F_PUSH = 4'b1000
    } t_fstate;

    t_fstate                          r_state, n_state;
    ustc_pkg::t_step                  r_step, n_step;
    logic [ustc_pkg::SECS_W-1:0]      r_num, n_num;
    logic [ustc_pkg::PROD_W-1:0]      r_prod;
    logic [ustc_pkg::SEC_W-1:0]       r_sec, n_sec;
    logic [ustc_pkg::MIN_W-1:0]       r_min, n_min;
    logic [ustc_pkg::HOUR_W-1:0]      r_hour, n_hour;

    logic [ustc_pkg::SECS_W-1:0]      magic;
    logic [ustc_pkg::SECS_W-1:0]      quot;
    logic [ustc_pkg::SECS_W-1:0]      back_mul;
    logic [ustc_pkg::SECS_W-1:0]      rem;

    assign magic = (r_step == ustc_pkg::STEP_HOUR) ? ustc_pkg::MAGIC_24 : ustc_pkg::MAGIC_60;

    // quotient and remainder of the current step
    always_comb begin
        if (r_step == ustc_pkg::STEP_HOUR) begin
            quot     = r_prod[ustc_pkg::PROD_W-1:32] >> 4;
            back_mul = (quot << 4) + (quot << 3);
        end else begin
            quot     = r_prod[ustc_pkg::PROD_W-1:32] >> 5;
            back_mul = (quot << 6) - (quot << 2);
        end
        rem = r_num - back_mul;
    end

    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        n_num   = r_num;
        n_sec   = r_sec;
        n_min   = r_min;
        n_hour  = r_hour;
        case (r_state)
            F_IDLE: begin
                if (i_in.valid) begin
                    n_num   = i_in.unix_seconds - ustc_pkg::EPOCH_OFFSET;
                    n_step  = ustc_pkg::STEP_SEC;
                    n_state = F_MUL;
                end
            end
            F_MUL: begin
                n_state = F_REM;
            end
            F_REM: begin
                n_num = quot;
                case (r_step)
                    ustc_pkg::STEP_SEC: begin
                        n_sec   = rem[ustc_pkg::SEC_W-1:0];
                        n_step  = ustc_pkg::STEP_MIN;
                        n_state = F_MUL;
                    end
                    ustc_pkg::STEP_MIN: begin
                        n_min   = rem[ustc_pkg::MIN_W-1:0];
                        n_step  = ustc_pkg::STEP_HOUR;
                        n_state = F_MUL;
                    end
                    default: begin
                        n_hour  = rem[ustc_pkg::HOUR_W-1:0];
                        n_state = F_PUSH;
                    end
                endcase
            end
            F_PUSH: begin
                if (i_item_ready) begin
                    n_state = F_IDLE;
                end
            end
            default: begin
                n_state = F_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
            r_step  <= ustc_pkg::STEP_SEC;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
        end
    end

    always_ff @(posedge i_clk) begin
        r_num  <= n_num;
        r_prod <= r_num * magic;
        r_sec  <= n_sec;
        r_min  <= n_min;
        r_hour <= n_hour;
    end

    assign i_in.ready      = (r_state == F_IDLE);
    assign o_item_valid    = (r_state == F_PUSH);
    assign o_item.days     = r_num[ustc_pkg::DAYS_W-1:0];
    assign o_item.hour     = r_hour;
    assign o_item.minute   = r_min;
    assign o_item.second   = r_sec;

endmodule

`default_nettype wire

>>> design/ustc_fifo.sv
// small queue between front and back
`timescale 1ns / 1ps
`default_nettype none

module ustc_fifo #(
    parameter int unsigned DEPTH = 2
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire ustc_pkg::t_item i_data,
    input  wire logic           i_push,
    output logic                o_ready,
    output ustc_pkg::t_item     o_data,
    output logic                o_valid,
    input  wire logic           i_pop
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

    ustc_pkg::t_item        r_mem [DEPTH];
    logic [PTR_W-1:0]       r_wr, n_wr;
    logic [PTR_W-1:0]       r_rd, n_rd;
    logic [CNT_W-1:0]       r_cnt, n_cnt;
    logic                   do_push;
    logic                   do_pop;

    assign o_ready = (r_cnt != FULL_CNT);
    assign o_valid = (r_cnt != '0);
    assign do_push = i_push && o_ready;
    assign do_pop  = i_pop && o_valid;
    assign o_data  = r_mem[r_rd];

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (do_push) begin
            n_wr = (r_wr == LAST_PTR) ? '0 : r_wr + 1'b1;
        end
        if (do_pop) begin
            n_rd = (r_rd == LAST_PTR) ? '0 : r_rd + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (do_pop && !do_push) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

`default_nettype wire

>>> design/ustc_back.sv
// back: year walk and month walk, one step per cycle, with output register
`timescale 1ns / 1ps
`default_nettype none

module ustc_back (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire ustc_pkg::t_item i_item,
    input  wire logic            i_item_valid,
    output logic                 o_item_pop,
    ustc_out_if.source           o_out
);

    typedef enum logic [3:0] {
        B_IDLE  = 4'b0001,
        B_YEAR  = 4'b0010,
        B_MONTH = 4'b0100,
        B_OUT   = 4'b1000
    } t_bstate;

    t_bstate                          r_state, n_state;
    logic [ustc_pkg::DAYS_W-1:0]      r_days, n_days;
    logic [ustc_pkg::YEAR_W-1:0]      r_year, n_year;
    logic [6:0]                       r_mod100, n_mod100;
    logic [8:0]                       r_mod400, n_mod400;
    logic [ustc_pkg::MONTH_W-1:0]     r_month, n_month;
    logic [ustc_pkg::DAY_W-1:0]       r_day, n_day;
    logic [ustc_pkg::HOUR_W-1:0]      r_hour, n_hour;
    logic [ustc_pkg::MIN_W-1:0]       r_min, n_min;
    logic [ustc_pkg::SEC_W-1:0]       r_sec, n_sec;

    logic                             leap;
    logic [ustc_pkg::YLEN_W-1:0]      year_len;
    logic [ustc_pkg::YLEN_W-1:0]      month_len;

    assign leap = ((r_year[1:0] == 2'b00) && (r_mod100 != '0)) || (r_mod400 == '0);
    assign year_len = leap ? ustc_pkg::LEAP_YEAR_DAYS : ustc_pkg::YEAR_DAYS;

    always_comb begin
        month_len = ustc_pkg::month_start(r_month) - ustc_pkg::month_start(r_month - 1'b1);
        if ((r_month == ustc_pkg::MONTH_FEB) && leap) begin
            month_len = month_len + 1'b1;
        end
    end

    always_comb begin
        n_state  = r_state;
        n_days   = r_days;
        n_year   = r_year;
        n_mod100 = r_mod100;
        n_mod400 = r_mod400;
        n_month  = r_month;
        n_day    = r_day;
        n_hour   = r_hour;
        n_min    = r_min;
        n_sec    = r_sec;
        case (r_state)
            B_IDLE: begin
                if (i_item_valid) begin
                    n_days   = i_item.days;
                    n_hour   = i_item.hour;
                    n_min    = i_item.minute;
                    n_sec    = i_item.second;
                    n_year   = ustc_pkg::BASE_YEAR;
                    n_mod100 = '0;
                    n_mod400 = '0;
                    n_state  = B_YEAR;
                end
            end
            B_YEAR: begin
                if (r_days >= ustc_pkg::DAYS_W'(year_len)) begin
                    n_days   = r_days - ustc_pkg::DAYS_W'(year_len);
                    n_year   = r_year + 1'b1;
                    n_mod100 = (r_mod100 == ustc_pkg::CENTURY_LAST) ? '0 : r_mod100 + 1'b1;
                    n_mod400 = (r_mod400 == ustc_pkg::QUAD_LAST) ? '0 : r_mod400 + 1'b1;
                end else begin
                    n_month = ustc_pkg::MONTH_JAN;
                    n_state = B_MONTH;
                end
            end
            B_MONTH: begin
                if ((r_month < ustc_pkg::MONTH_DEC) &&
                    (r_days >= ustc_pkg::DAYS_W'(month_len))) begin
                    n_days  = r_days - ustc_pkg::DAYS_W'(month_len);
                    n_month = r_month + 1'b1;
                end else begin
                    n_day   = r_days[ustc_pkg::DAY_W-1:0] + 1'b1;
                    n_state = B_OUT;
                end
            end
            B_OUT: begin
                if (o_out.ready) begin
                    n_state = B_IDLE;
                end
            end
            default: begin
                n_state = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= B_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_days   <= n_days;
        r_year   <= n_year;
        r_mod100 <= n_mod100;
        r_mod400 <= n_mod400;
        r_month  <= n_month;
        r_day    <= n_day;
        r_hour   <= n_hour;
        r_min    <= n_min;
        r_sec    <= n_sec;
    end

    assign o_item_pop   = (r_state == B_IDLE);
    assign o_out.valid  = (r_state == B_OUT);
    assign o_out.year   = r_year;
    assign o_out.month  = r_month;
    assign o_out.day    = r_day;
    assign o_out.hour   = r_hour;
    assign o_out.minute = r_min;
    assign o_out.second = r_sec;

endmodule

`default_nettype wire

>>> bench/unix_seconds_to_calendar_unit_tb.sv
// self-checking testbench of the unix seconds to calendar unit
`timescale 1ns / 1ps

module unix_seconds_to_calendar_unit_tb;

    // one calendar result, laid out like the output beat
    typedef struct packed {
        logic [ustc_pkg::YEAR_W-1:0]  year;
        logic [ustc_pkg::MONTH_W-1:0] month;
        logic [ustc_pkg::DAY_W-1:0]   day;
        logic [ustc_pkg::HOUR_W-1:0]  hour;
        logic [ustc_pkg::MIN_W-1:0]   minute;
        logic [ustc_pkg::SEC_W-1:0]   second;
    } t_calendar;

    localparam int unsigned DAY_SECS     = 86400;
    localparam int unsigned RANDOM_ITEMS = 1100;
    localparam int unsigned PHASE_ITEMS  = RANDOM_ITEMS / 4;
    localparam int unsigned DRAIN_CYCLES = 200;
    localparam int unsigned REPORT_LIMIT = 10;

    // plain month lengths, february fixed up for leap years below
    localparam int unsigned MONTH_LEN [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

    logic i_clk;
    logic i_rst_n;

    ustc_in_if  in_ch ();
    ustc_out_if out_ch ();

    unix_seconds_to_calendar_unit uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    // dates still owed by the unit, oldest first
    t_calendar   pending_dates [$];
    int unsigned idle_pct;
    int unsigned stall_pct;
    int unsigned stamps_sent;
    int unsigned directed_sent;
    int unsigned dates_checked;
    int unsigned failures;

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // ---------------------------------------------------------------- calendar arithmetic

    // gregorian rule: every fourth year, not centuries, but every fourth century
    function automatic bit is_leap(input int unsigned y);
        return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
    endfunction

    function automatic int unsigned month_days(input int unsigned y, input int unsigned m);
        return MONTH_LEN[m-1] + ((m == 2 && is_leap(y)) ? 1 : 0);
    endfunction

    // expected calendar fields of one timestamp
    function automatic t_calendar calendar_of(input logic [ustc_pkg::SECS_W-1:0] secs);
        logic [ustc_pkg::SECS_W-1:0] rel;
        int unsigned                 days;
        int unsigned                 y;
        int unsigned                 mo;
        t_calendar                   c;
        // pre-2000 stamps wrap around to the far end of the range
        rel      = secs - ustc_pkg::EPOCH_OFFSET;
        c.second = ustc_pkg::SEC_W'(rel % 60);
        c.minute = ustc_pkg::MIN_W'((rel / 60) % 60);
        c.hour   = ustc_pkg::HOUR_W'((rel / 3600) % 24);
        days     = rel / DAY_SECS;
        y        = 2000;
        while (days >= (is_leap(y) ? 366 : 365)) begin
            days -= is_leap(y) ? 366 : 365;
            y++;
        end
        mo = 1;
        while (mo < 12 && days >= month_days(y, mo)) begin
            days -= month_days(y, mo);
            mo++;
        end
        c.year  = ustc_pkg::YEAR_W'(y);
        c.month = ustc_pkg::MONTH_W'(mo);
        c.day   = ustc_pkg::DAY_W'(days + 1);
        return c;
    endfunction

    // timestamp of a calendar date, going the other way, to aim stimulus at boundaries
    function automatic logic [ustc_pkg::SECS_W-1:0] stamp_of(
        input int unsigned y, input int unsigned mo, input int unsigned d,
        input int unsigned h, input int unsigned mi, input int unsigned s);
        longint unsigned total;
        total = 0;
        for (int unsigned yy = 2000; yy < y; yy++)
            total += is_leap(yy) ? 366 : 365;
        for (int unsigned m = 1; m < mo; m++)
            total += month_days(y, m);
        total = (total + d - 1) * DAY_SECS + h * 3600 + mi * 60 + s;
        return ustc_pkg::SECS_W'(total + ustc_pkg::EPOCH_OFFSET);
    endfunction

    // mostly calendar-shaped stamps near month and year edges, some around the 2000 epoch, the rest raw noise
    function automatic logic [ustc_pkg::SECS_W-1:0] pick_stamp();
        int unsigned sel;
        int unsigned y;
        int unsigned mo;
        int unsigned d;
        int unsigned h;
        int unsigned mi;
        int unsigned s;
        sel = $urandom_range(0, 9);
        if (sel < 3)
            return $urandom();
        if (sel == 3)
            return ustc_pkg::EPOCH_OFFSET + $urandom_range(0, 400) - 200;
        y  = $urandom_range(2000, 2135);
        mo = $urandom_range(1, 12);
        if (sel == 4) begin
            // february of a quad century, a century, a multiple-of-four year or the random year
            case ($urandom_range(0, 3))
                0:       y = 2000;
                1:       y = 2100;
                2:       y = 2000 + 4 * $urandom_range(0, 33);
                default: ;
            endcase
            mo = 2;
        end
        case ($urandom_range(0, 2))
            0:       d = 1;
            1:       d = month_days(y, mo);
            default: d = $urandom_range(1, month_days(y, mo));
        endcase
        case ($urandom_range(0, 2))
            0: begin
                h = 0; mi = 0; s = 0;
            end
            1: begin
                h = 23; mi = 59; s = 59;
            end
            default: begin
                h = $urandom_range(0, 23); mi = $urandom_range(0, 59); s = $urandom_range(0, 59);
            end
        endcase
        return stamp_of(y, mo, d, h, mi, s);
    endfunction

    // ---------------------------------------------------------------- driving

    // one input beat, with random idle cycles ahead of it
    task automatic send_stamp(input logic [ustc_pkg::SECS_W-1:0] secs);
        @(negedge i_clk);
        while ($urandom_range(0, 99) < idle_pct) begin
            in_ch.valid = 1'b0;
            @(negedge i_clk);
        end
        in_ch.valid        = 1'b1;
        in_ch.unix_seconds = secs;
        do @(posedge i_clk); while (!in_ch.ready);
        pending_dates.push_back(calendar_of(secs));
        stamps_sent++;
    endtask

    // receiver back-pressure, redrawn every cycle
    always @(negedge i_clk) begin
        out_ch.ready = ($urandom_range(0, 99) >= stall_pct);
    end

    // ---------------------------------------------------------------- checking

    task automatic note_failure(input string what, input int unsigned want,
                                input int unsigned got);
        failures++;
        if (failures <= REPORT_LIMIT)
            $display("[%0t] %s: expected %0d, got %0d", $realtime, what, want, got);
    endtask

    always @(posedge i_clk) begin
        t_calendar want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (pending_dates.size() == 0) begin
                note_failure("result beat with nothing outstanding", 0, out_ch.year);
            end else begin
                want = pending_dates.pop_front();
                dates_checked++;
                if (out_ch.year !== want.year)     note_failure("year", want.year, out_ch.year);
                if (out_ch.month !== want.month)   note_failure("month", want.month, out_ch.month);
                if (out_ch.day !== want.day)       note_failure("day", want.day, out_ch.day);
                if (out_ch.hour !== want.hour)     note_failure("hour", want.hour, out_ch.hour);
                if (out_ch.minute !== want.minute) note_failure("minute", want.minute, out_ch.minute);
                if (out_ch.second !== want.second) note_failure("second", want.second, out_ch.second);
            end
        end
    end

    // ---------------------------------------------------------------- tests

    // field extremes, epoch wrap and the leap-year edges
    task automatic test_directed();
        idle_pct  = 0;
        stall_pct = 0;
        send_stamp(32'd0);                             // 1970 wraps into 2106
        send_stamp(32'hFFFF_FFFF);
        send_stamp(ustc_pkg::EPOCH_OFFSET);            // 2000-01-01 00:00:00
        send_stamp(ustc_pkg::EPOCH_OFFSET - 1);        // largest offset, early 2136
        send_stamp(ustc_pkg::EPOCH_OFFSET + 1);
        send_stamp(32'h8000_0000);
        send_stamp(32'hAAAA_AAAA);
        send_stamp(32'h5555_5555);
        send_stamp(stamp_of(2000, 2, 29, 23, 59, 59));
        send_stamp(stamp_of(2000, 3, 1, 0, 0, 0));
        send_stamp(stamp_of(2000, 12, 31, 23, 59, 59));
        send_stamp(stamp_of(2004, 2, 29, 12, 30, 30));
        send_stamp(stamp_of(2096, 12, 31, 23, 59, 59));
        send_stamp(stamp_of(2100, 2, 28, 23, 59, 59)); // century, not leap
        send_stamp(stamp_of(2100, 3, 1, 0, 0, 0));
        send_stamp(stamp_of(2135, 12, 31, 23, 59, 59));
        send_stamp(stamp_of(2136, 1, 1, 0, 0, 0));
        for (int unsigned m = 1; m <= 12; m += 4)
            send_stamp(stamp_of(2024, m, month_days(2024, m), 23, 59, 59));
        directed_sent = stamps_sent;
    endtask

    task automatic random_stamps(input int unsigned idle, input int unsigned stall);
        idle_pct  = idle;
        stall_pct = stall;
        repeat (PHASE_ITEMS) send_stamp(pick_stamp());
    endtask

    task automatic test_back_to_back();
        random_stamps(0, 0);
    endtask

    task automatic test_sender_gaps();
        random_stamps(54, 0);
    endtask

    task automatic test_receiver_stalls();
        random_stamps(0, 54);
    endtask

    task automatic test_both_throttled();
        random_stamps(35, 35);
    endtask

    // ---------------------------------------------------------------- sequence

    initial begin
        i_rst_n            = 1'b0;
        in_ch.valid        = 1'b0;
        in_ch.unix_seconds = '0;
        out_ch.ready       = 1'b0;
        idle_pct           = 0;
        stall_pct          = 0;
        stamps_sent        = 0;
        directed_sent      = 0;
        dates_checked      = 0;
        failures           = 0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_directed();
        test_back_to_back();
        test_sender_gaps();
        test_receiver_stalls();
        test_both_throttled();

        @(negedge i_clk);
        in_ch.valid = 1'b0;
        stall_pct   = 0;
        while (pending_dates.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("sent %0d timestamps (%0d directed edges, rest random over four throttle mixes)",
                 stamps_sent, directed_sent);
        $display("compared %0d calendar results, %0d field or ordering errors",
                 dates_checked, failures);
        if (failures == 0)
            $display("unix_seconds_to_calendar_unit verification clean");
        else
            $display("unix_seconds_to_calendar_unit verification failed");
        $finish;
    end

    // hard stop well past the slowest legal run
    initial begin
        #8000000;
        $display("timeout with %0d results outstanding", pending_dates.size());
        $display("unix_seconds_to_calendar_unit verification failed");
        $finish;
    end

endmodule
